// ===== rtl/core/qsd_pkg.sv =====
// qsd_pkg: shared types, character codes and hex helper for the query string decoder
// used by qsd_step, qsd_queue, query_string_decoder_top and its checker
// no dependencies
package qsd_pkg;

  // decoder phase codes
  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_VALUE = 3'd1,
    PH_HEX1  = 3'd2,
    PH_HEX2  = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  // result item kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // special characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic       pair_ok;
    logic       bad_escape;
    logic       run_last;
  } out_t;

  // decoder state carried between beats
  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic       high_valid;
    logic       name_seen;
    logic       value_seen;
  } st_t;

  // up to two results from one input beat
  typedef struct packed {
    logic [1:0]      count;
    out_t [1:0]      item;
  } res_pair_t;

  // hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic out_t mk_item(input logic [7:0] b, input logic [1:0] kind,
                                   input logic ok, input logic bad);
    out_t r;
    r.out_byte   = b;
    r.item_kind  = kind;
    r.pair_ok    = ok;
    r.bad_escape = bad;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/query_string_decoder_top.sv =====
// query_string_decoder_top: form-urlencoded query string decoder, one byte per beat
// instantiates qsd_step and qsd_queue; depends on qsd_pkg
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | qsd_pkg::in_t  (in_byte, in_last)
//   out     | output    | out_valid / out_ready | qsd_pkg::out_t (out_byte, item_kind, ...)
//
// one input beat is taken each cycle while the result queue has two free entries
// each beat yields 0, 1 or 2 results; the result port drains one per cycle while
// out_ready is high, so the single output port sets the rate when beats give two results
// a beat's results are registered in the queue and leave behind those already waiting
// rst_n low clears the decoder state and empties the queue
// a stalled out side lets the queue reach three or four entries, then in_ready drops
module query_string_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qsd_pkg::out_t out_data
);

  qsd_pkg::st_t       st_r, st_nxt;
  qsd_pkg::res_pair_t res;
  logic               accept;

  assign accept = in_valid && in_ready;

  qsd_step u_step (
    .st_i   (st_r),
    .beat_i (in_data),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= qsd_pkg::PH_NAME;
      st_r.high_nibble <= 4'd0;
      st_r.high_valid  <= 1'b0;
      st_r.name_seen   <= 1'b0;
      st_r.value_seen  <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  qsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (accept),
    .res_i     (res),
    .room_o    (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/qsd_step.sv =====
// qsd_step: combinational decode of one input beat against the current state
// produces next state and up to two result items; depends on qsd_pkg
module qsd_step (
  input  qsd_pkg::st_t      st_i,
  input  qsd_pkg::in_t      beat_i,
  output qsd_pkg::st_t      st_o,
  output qsd_pkg::res_pair_t res_o
);

  qsd_pkg::phase_t ph;
  logic [3:0]      hn;
  logic            hv;
  logic            ns;
  logic            vs;
  logic            closed;
  logic [1:0]      cnt;
  logic [7:0]      b;
  logic [4:0]      hx;
  logic [7:0]      cut_v;
  qsd_pkg::out_t [1:0] item;

  assign b  = beat_i.in_byte;
  assign hx = qsd_pkg::hex_digit(b);

  // sequential walk of the byte rules, at most two emits
  always_comb begin
    ph     = st_i.phase;
    hn     = st_i.high_nibble;
    hv     = st_i.high_valid;
    ns     = st_i.name_seen;
    vs     = st_i.value_seen;
    closed = 1'b0;
    cnt    = 2'd0;
    item   = '0;
    cut_v  = 8'd0;

    case (ph)
      qsd_pkg::PH_SKIP: begin
      end
      qsd_pkg::PH_VALUE: begin
        if (b == qsd_pkg::CH_AMP) begin
          item[cnt[0]] = qsd_pkg::mk_item(8'd0, qsd_pkg::KIND_END, ns & vs, 1'b0);
          cnt = cnt + 2'd1;
          ph = qsd_pkg::PH_NAME; hn = 4'd0; hv = 1'b0; ns = 1'b0; vs = 1'b0;
          closed = 1'b1;
        end else if (b == qsd_pkg::CH_SPACE) begin
          ph = qsd_pkg::PH_SKIP;
        end else if (b == qsd_pkg::CH_PCT) begin
          ph = qsd_pkg::PH_HEX1;
        end else if (b == qsd_pkg::CH_PLUS) begin
          item[cnt[0]] = qsd_pkg::mk_item(qsd_pkg::CH_SPACE, qsd_pkg::KIND_VALUE,
                                          1'b0, 1'b0);
          cnt = cnt + 2'd1;
          vs = 1'b1;
        end else begin
          item[cnt[0]] = qsd_pkg::mk_item(b, qsd_pkg::KIND_VALUE, 1'b0, 1'b0);
          cnt = cnt + 2'd1;
          vs = 1'b1;
        end
      end
      qsd_pkg::PH_HEX1, qsd_pkg::PH_HEX2: begin
        if (b == qsd_pkg::CH_AMP || b == qsd_pkg::CH_SPACE) begin
          // escape cut off by a separator
          cut_v = (ph == qsd_pkg::PH_HEX2 && hv) ? {4'd0, hn} : 8'd0;
          item[cnt[0]] = qsd_pkg::mk_item(cut_v, qsd_pkg::KIND_VALUE, 1'b0, 1'b1);
          cnt = cnt + 2'd1;
          vs = 1'b1;
          ph = qsd_pkg::PH_VALUE;
          if (b == qsd_pkg::CH_AMP) begin
            item[cnt[0]] = qsd_pkg::mk_item(8'd0, qsd_pkg::KIND_END, ns & vs, 1'b0);
            cnt = cnt + 2'd1;
            ph = qsd_pkg::PH_NAME; hn = 4'd0; hv = 1'b0; ns = 1'b0; vs = 1'b0;
            closed = 1'b1;
          end else begin
            ph = qsd_pkg::PH_SKIP;
          end
        end else if (ph == qsd_pkg::PH_HEX1) begin
          hv = hx[4];
          hn = hx[4] ? hx[3:0] : 4'd0;
          ph = qsd_pkg::PH_HEX2;
        end else if (hx[4] && hv) begin
          ph = qsd_pkg::PH_VALUE;
          item[cnt[0]] = qsd_pkg::mk_item({hn, hx[3:0]}, qsd_pkg::KIND_VALUE,
                                          1'b0, 1'b0);
          cnt = cnt + 2'd1;
          vs = 1'b1;
        end else begin
          // bad first or second digit
          cut_v = hv ? {4'd0, hn} : 8'd0;
          item[cnt[0]] = qsd_pkg::mk_item(cut_v, qsd_pkg::KIND_VALUE, 1'b0, 1'b1);
          cnt = cnt + 2'd1;
          vs = 1'b1;
          ph = qsd_pkg::PH_VALUE;
        end
      end
      default: begin
        // name phase, unused codes included
        if (b == qsd_pkg::CH_AMP) begin
          item[cnt[0]] = qsd_pkg::mk_item(8'd0, qsd_pkg::KIND_END, ns & vs, 1'b0);
          cnt = cnt + 2'd1;
          ph = qsd_pkg::PH_NAME; hn = 4'd0; hv = 1'b0; ns = 1'b0; vs = 1'b0;
          closed = 1'b1;
        end else if (b == qsd_pkg::CH_SPACE) begin
          ph = qsd_pkg::PH_SKIP;
        end else if (b == qsd_pkg::CH_EQ) begin
          ph = qsd_pkg::PH_VALUE;
        end else begin
          item[cnt[0]] = qsd_pkg::mk_item(b, qsd_pkg::KIND_NAME, 1'b0, 1'b0);
          cnt = cnt + 2'd1;
          ns = 1'b1;
        end
      end
    endcase

    // end of string: flush a pending escape, close the pair, back to reset
    if (beat_i.in_last) begin
      if (ph == qsd_pkg::PH_HEX1 || ph == qsd_pkg::PH_HEX2) begin
        cut_v = (ph == qsd_pkg::PH_HEX2 && hv) ? {4'd0, hn} : 8'd0;
        item[cnt[0]] = qsd_pkg::mk_item(cut_v, qsd_pkg::KIND_VALUE, 1'b0, 1'b1);
        cnt = cnt + 2'd1;
        vs = 1'b1;
      end
      if (!closed) begin
        item[cnt[0]] = qsd_pkg::mk_item(8'd0, qsd_pkg::KIND_END, ns & vs, 1'b0);
        cnt = cnt + 2'd1;
      end
      ph = qsd_pkg::PH_NAME; hn = 4'd0; hv = 1'b0; ns = 1'b0; vs = 1'b0;
    end

    // mark the last result of this beat
    if (cnt == 2'd2) begin
      item[1].run_last = 1'b1;
    end else if (cnt == 2'd1) begin
      item[0].run_last = 1'b1;
    end
  end

  always_comb begin
    st_o.phase       = ph;
    st_o.high_nibble = hn;
    st_o.high_valid  = hv;
    st_o.name_seen   = ns;
    st_o.value_seen  = vs;
    res_o.count      = cnt;
    res_o.item       = item;
  end

endmodule

// ===== rtl/core/qsd_queue.sv =====
// qsd_queue: four-entry result queue, up to two writes and one read per cycle
// keeps the input side moving while results wait; depends on qsd_pkg
module qsd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  qsd_pkg::res_pair_t res_i,
  output logic               room_o,
  output logic               out_valid,
  input  logic               out_ready,
  output qsd_pkg::out_t      out_data
);

  qsd_pkg::out_t [3:0] ent_r;
  logic [1:0]          wp_r, wp_nxt;
  logic [1:0]          rp_r, rp_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [1:0]          wr_n;
  logic                pop;

  assign wr_n      = push_i ? res_i.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = ent_r[rp_r];
  // room for the worst case of two results
  assign room_o    = (cnt_r <= 3'd2);

  // pointer and fill count
  always_comb begin
    wp_nxt  = wp_r + wr_n;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_n} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      ent_r[wp_r] <= res_i.item[0];
    end
    if (wr_n == 2'd2) begin
      ent_r[wp_r + 2'd1] <= res_i.item[1];
    end
  end

endmodule

// ===== rtl/core/qsd_checker.sv =====
// qsd_checker: port-level assertions for query_string_decoder_top
// bound to the top level below; depends on qsd_pkg
module qsd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input qsd_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // pair end carries no byte and no escape flag
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == qsd_pkg::KIND_END |->
      out_data.out_byte == 8'd0 && !out_data.bad_escape)
    else $error("pair end with byte or escape flag");

  // name bytes never carry pair or escape flags
  a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == qsd_pkg::KIND_NAME |->
      !out_data.pair_ok && !out_data.bad_escape)
    else $error("name byte with flags set");

  // an offered beat is taken while nothing is pending
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled with nothing pending");

endmodule

bind query_string_decoder_top qsd_checker u_qsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
